FILE: rtl/core/assert_macros.svh
// Assertion macros for the RTL of the sorted descending table.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Checks that a condition is never true at a clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

FILE: rtl/core/sdt_pkg.sv
// Package of the sorted descending table: request and response types, codes
// and default sizes. It depends on nothing else.
package sdt_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int ENTRY_W   = 32;
    localparam int COUNT_W   = 5;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_DELETE = 2'd1;
    localparam logic [1:0] MODE_DUMP   = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic [1:0]                 mode;
        logic signed [ENTRY_W-1:0]  value;
    } t_req;

    typedef struct packed {
        logic signed [ENTRY_W-1:0]  entry;
        logic [COUNT_W-1:0]         count;
        logic [1:0]                 status;
        logic                       last;
    } t_rsp;

endpackage

FILE: rtl/core/sorted_descending_table_top.sv
// Top level of the sorted descending table; uses sdt_pkg, sdt_ram and
// assert_macros.svh.
//
// The block keeps up to DEPTH signed 32-bit values in descending order in one
// RAM and serves one request at a time; every request gives at least one
// response. A refused insert, an insert into an empty table, a delete of an
// empty table, an empty dump and an unused mode go straight from idle to the
// response state. Any other insert moves each entry smaller than its value up
// one place, then writes the value in the gap; a delete reads the whole table
// once and writes back the survivors. A dump gives one response per cycle
// while the response side takes them. The pace of every request is set by the
// single read and write port of the RAM, and a stalled response side holds it
// back. Responses sit in an output register, so a new request may be taken
// while the last response waits.
module sorted_descending_table_top
    import sdt_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_req i_in_req,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_rsp o_out_rsp
);

`include "assert_macros.svh"

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_INS_CMP = 6'b000010,
        S_INS_PUT = 6'b000100,
        S_DEL_CMP = 6'b001000,
        S_DUMP    = 6'b010000,
        S_RESP    = 6'b100000
    } t_state;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [AW-1:0]         r_idx, n_idx;
    logic [CW-1:0]         r_wr, n_wr;
    logic signed [ENTRY_W-1:0] r_value, n_value;
    logic [1:0]            r_status, n_status;
    logic                  r_out_valid, n_out_valid;
    t_rsp                  r_out_rsp, n_out_rsp;

    logic                  in_fire;
    logic                  out_free;
    logic                  out_load;
    logic                  idx_last;
    logic                  keep;
    logic [CW-1:0]         wr_next;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [ENTRY_W-1:0]    ram_wdata;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [ENTRY_W-1:0]    ram_rdata;

    sdt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign idx_last    = ((CW'(r_idx) + CW'(1)) == r_count);
    assign keep        = (ram_rdata != r_value);
    assign wr_next     = r_wr + CW'(keep);
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_wr      = r_wr;
        n_value   = r_value;
        n_status  = r_status;
        n_out_rsp = r_out_rsp;
        out_load  = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = r_value;
        ram_re    = 1'b0;
        ram_raddr = '0;

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_value  = i_in_req.value;
                    n_status = ST_OK;
                    n_idx    = '0;
                    n_wr     = '0;
                    case (i_in_req.mode)
                        MODE_INSERT: begin
                            if (r_count >= CW'(DEPTH)) begin
                                n_status = ST_FULL;
                                n_state  = S_RESP;
                            end else if (r_count == '0) begin
                                ram_we    = 1'b1;
                                ram_wdata = i_in_req.value;
                                n_count   = CW'(1);
                                n_state   = S_RESP;
                            end else begin
                                n_idx     = AW'(r_count - CW'(1));
                                ram_re    = 1'b1;
                                ram_raddr = n_idx;
                                n_state   = S_INS_CMP;
                            end
                        end
                        MODE_DELETE: begin
                            if (r_count == '0) begin
                                n_status = ST_NOTFOUND;
                                n_state  = S_RESP;
                            end else begin
                                ram_re  = 1'b1;
                                n_state = S_DEL_CMP;
                            end
                        end
                        MODE_DUMP: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_RESP;
                            end else begin
                                ram_re  = 1'b1;
                                n_state = S_DUMP;
                            end
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end
            end
            S_INS_CMP: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx + AW'(1);
                if ($signed(ram_rdata) < r_value) begin
                    ram_wdata = ram_rdata;
                    if (r_idx == '0) begin
                        n_state = S_INS_PUT;
                    end else begin
                        n_idx     = r_idx - AW'(1);
                        ram_re    = 1'b1;
                        ram_raddr = n_idx;
                    end
                end else begin
                    ram_wdata = r_value;
                    n_count   = r_count + CW'(1);
                    n_state   = S_RESP;
                end
            end
            S_INS_PUT: begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = r_value;
                n_count   = r_count + CW'(1);
                n_state   = S_RESP;
            end
            S_DEL_CMP: begin
                if (keep) begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(r_wr);
                    ram_wdata = ram_rdata;
                end
                n_wr = wr_next;
                if (idx_last) begin
                    n_count  = wr_next;
                    n_status = (wr_next == r_count) ? ST_NOTFOUND : ST_OK;
                    n_state  = S_RESP;
                end else begin
                    n_idx     = r_idx + AW'(1);
                    ram_re    = 1'b1;
                    ram_raddr = n_idx;
                end
            end
            S_DUMP: begin
                if (out_free) begin
                    out_load         = 1'b1;
                    n_out_rsp.entry  = ram_rdata;
                    n_out_rsp.count  = COUNT_W'(r_count);
                    n_out_rsp.status = ST_OK;
                    n_out_rsp.last   = idx_last;
                    if (idx_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx     = r_idx + AW'(1);
                        ram_re    = 1'b1;
                        ram_raddr = n_idx;
                    end
                end
            end
            S_RESP: begin
                if (out_free) begin
                    out_load         = 1'b1;
                    n_out_rsp.entry  = '0;
                    n_out_rsp.count  = COUNT_W'(r_count);
                    n_out_rsp.status = r_status;
                    n_out_rsp.last   = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out_valid = out_load || (r_out_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_wr      <= n_wr;
        r_value   <= n_value;
        r_status  <= n_status;
        r_out_rsp <= n_out_rsp;
    end

    `ASSERT_NEVER(a_count_bound, r_count > CW'(DEPTH), "entry count above depth")
    `ASSERT_NEVER(a_no_overwrite, out_load && r_out_valid && !i_out_ready, "response overwritten")
    `ASSERT_CLK(a_busy_after_accept, in_fire |=> (r_state != S_IDLE), "request not started")
    `ASSERT_CLK(a_idle_count, (r_state == S_IDLE) && !in_fire |=> (r_count == $past(r_count)), "count moved while idle")

endmodule

FILE: rtl/core/sdt_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// It depends on nothing else.
module sdt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
